// ===== rtl/core/pdc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the packet deframer.
// No dependencies; every module of the block imports this package, the two interfaces do not.
package pdc_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int HC_W         = $clog2(HEADER_BYTES);
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [31:0] MAGIC_WORD        = 32'h4549_5131;  // "EIQ1"
   localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES          = 32'hFFFF_FFFF;
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

   // result kind of a beat
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DROP    = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_MAGIC   = 3'd1,
      ST_OVERSIZE    = 3'd2,
      ST_CRC_BAD     = 3'd3,
      ST_CLOSED_MID  = 3'd4,
      ST_CLEAN_CLOSE = 3'd5
   } status_type;

   // One queued work item: a single beat, or a data beat followed by a
   // status beat when pair is set.
   typedef struct packed {
      logic        pair;
      logic        kind;
      logic [7:0]  data;
      status_type  status;
      logic [31:0] ptype;
      logic [31:0] plen;
   } entry_type;

   // Reflected CRC-32 update over one byte, LSB first.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/pdc_req_if.sv =====
// Input channel of the packet deframer: one stream byte or a close marker.
// Plain valid/ready handshake; no package dependency.
interface pdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       peer_closed;

   modport source (output valid, output data_byte, output peer_closed, input ready);
   modport sink   (input valid, input data_byte, input peer_closed, output ready);
endinterface

// ===== rtl/core/pdc_rsp_if.sv =====
// Result channel of the packet deframer: forwarded payload bytes and status.
// Plain valid/ready handshake; no package dependency.
interface pdc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [2:0]  status;
   logic [31:0] packet_type;
   logic [31:0] payload_length;
   logic        last;

   modport source (output valid, output result_kind, output payload_byte,
                   output status, output packet_type, output payload_length,
                   output last, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input status, input packet_type, input payload_length,
                   input last, output ready);
endinterface

// ===== rtl/core/pdc_front.sv =====
// Front end: accepts stream beats, parses the header, runs the CRC and
// pushes one work entry per beat that causes results. Uses pdc_pkg, pdc_req_if.
module pdc_front import pdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   pdc_req_if.sink     req,
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_entry
);

   localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_BYTES - 1);

   phase_type       phase_ff, phase_in;
   logic [HC_W-1:0] hc_ff, hc_in;
   logic [31:0]     type_ff, type_in;
   logic [31:0]     len_ff, len_in;
   logic [31:0]     exp_ff, exp_in;
   logic [31:0]     magic_ff, magic_in;
   logic [31:0]     remain_ff, remain_in;
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     max_payload_ff;

   logic        accept;
   logic [31:0] crc_next;
   logic [31:0] remain_dec;

   assign req.ready  = !q_full;
   assign accept     = req.valid && req.ready;
   assign crc_next   = crc32_byte(crc_ff, req.data_byte);
   assign remain_dec = remain_ff - 32'd1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hc_ff     <= '0;
         type_ff   <= '0;
         len_ff    <= '0;
         exp_ff    <= '0;
         magic_ff  <= '0;
         remain_ff <= '0;
         crc_ff    <= ALL_ONES;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hc_ff     <= hc_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         exp_ff    <= exp_in;
         magic_ff  <= magic_in;
         remain_ff <= remain_in;
         crc_ff    <= crc_in;
      end
   end

   // next state and queued work
   always_comb begin
      logic clear;
      clear     = 1'b0;
      phase_in  = phase_ff;
      hc_in     = hc_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      exp_in    = exp_ff;
      magic_in  = magic_ff;
      remain_in = remain_ff;
      crc_in    = crc_ff;
      q_push    = 1'b0;
      q_entry.pair   = 1'b0;
      q_entry.kind   = KIND_STATUS;
      q_entry.data   = 8'd0;
      q_entry.status = ST_OK;
      q_entry.ptype  = type_ff;
      q_entry.plen   = len_ff;

      if (req.peer_closed) begin
         // close: report per phase (nothing while dropping), then start over
         clear = 1'b1;
         unique case (phase_ff)
            PH_HEADER: begin
               q_push         = accept;
               q_entry.status = (hc_ff == '0) ? ST_CLEAN_CLOSE : ST_CLOSED_MID;
               q_entry.ptype  = 32'd0;
               q_entry.plen   = 32'd0;
            end
            PH_PAYLOAD: begin
               q_push         = accept;
               q_entry.status = ST_CLOSED_MID;
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               // shift the byte into its header word
               unique case (hc_ff[HC_W-1:HC_W-2])
                  2'd0: magic_in = {magic_ff[23:0], req.data_byte};
                  2'd1: type_in  = {type_ff[23:0], req.data_byte};
                  2'd2: len_in   = {len_ff[23:0], req.data_byte};
                  default: exp_in = {exp_ff[23:0], req.data_byte};
               endcase
               q_entry.ptype = type_in;
               q_entry.plen  = len_in;
               if (hc_ff != HC_LAST) begin
                  hc_in = hc_ff + 1'b1;
               end else begin
                  hc_in = '0;
                  priority if (magic_in != MAGIC_WORD) begin
                     q_push         = accept;
                     q_entry.status = ST_BAD_MAGIC;
                     phase_in       = PH_DROP;
                  end else if (len_in > max_payload_ff) begin
                     q_push         = accept;
                     q_entry.status = ST_OVERSIZE;
                     phase_in       = PH_DROP;
                  end else if (len_in == 32'd0) begin
                     q_push         = accept;
                     q_entry.status = (exp_in == 32'd0) ? ST_OK : ST_CRC_BAD;
                     clear          = 1'b1;
                  end else begin
                     phase_in  = PH_PAYLOAD;
                     remain_in = len_in;
                     crc_in    = ALL_ONES;
                  end
               end
            end
            PH_PAYLOAD: begin
               // forward the byte; on the final one queue the check result too
               crc_in         = crc_next;
               remain_in      = remain_dec;
               q_push         = accept;
               q_entry.kind   = KIND_DATA;
               q_entry.data   = req.data_byte;
               if (remain_dec == 32'd0) begin
                  q_entry.pair   = 1'b1;
                  q_entry.status = ((crc_next ^ ALL_ONES) == exp_ff) ? ST_OK : ST_CRC_BAD;
                  clear          = 1'b1;
               end
            end
            default: begin
               // drop bytes until close
               q_push = 1'b0;
            end
         endcase
      end

      if (clear) begin
         phase_in  = PH_HEADER;
         hc_in     = '0;
         type_in   = '0;
         len_in    = '0;
         exp_in    = '0;
         magic_in  = '0;
         remain_in = '0;
         crc_in    = ALL_ONES;
      end
   end

endmodule

// ===== rtl/core/pdc_queue.sv =====
// Short work queue between the front end and the result sequencer.
// Register-based circular buffer; uses pdc_pkg for the entry type and depth.
module pdc_queue import pdc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head_entry,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/core/pdc_back.sv =====
// Back end: turns queued work entries into result beats, two for the final
// payload byte of a frame. Uses pdc_pkg and pdc_rsp_if.
module pdc_back import pdc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type head_entry,
   input  logic      q_empty,
   output logic      q_pop,
   pdc_rsp_if.source rsp
);

   logic sub_ff, sub_in;
   logic fire;

   assign fire  = rsp.valid && rsp.ready;
   assign q_pop = fire && (!head_entry.pair || sub_ff);

   // track which half of a paired entry is showing
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

   always_comb begin
      sub_in = sub_ff;
      if (fire) begin
         sub_in = head_entry.pair && !sub_ff;
      end
   end

   // drive the beat from the queue head
   always_comb begin
      rsp.valid          = !q_empty;
      rsp.packet_type    = head_entry.ptype;
      rsp.payload_length = head_entry.plen;
      if (head_entry.pair && !sub_ff) begin
         rsp.result_kind  = KIND_DATA;
         rsp.payload_byte = head_entry.data;
         rsp.status       = ST_OK;
         rsp.last         = 1'b0;
      end else if (head_entry.pair) begin
         rsp.result_kind  = KIND_STATUS;
         rsp.payload_byte = 8'd0;
         rsp.status       = head_entry.status;
         rsp.last         = 1'b1;
      end else begin
         rsp.result_kind  = head_entry.kind;
         rsp.payload_byte = head_entry.data;
         rsp.status       = head_entry.status;
         rsp.last         = 1'b1;
      end
   end

endmodule

// ===== rtl/core/packet_deframer_crc32_check.sv =====
// Packet deframer with CRC-32 check. Takes one stream byte (or a close marker)
// per beat and returns forwarded payload bytes and a status beat per frame.
// The input side takes a byte every cycle as long as the four-entry work
// queue has room; each result passes through the queue before it is shown.
// The final payload byte of a frame yields two result beats (the byte, then
// the CRC status), sent one after the other; the queue absorbs that, so
// while the result side is not stalled the sustained rate is one byte per
// cycle. No clearing pass after reset. Write max_payload only while idle.
module packet_deframer_crc32_check import pdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   pdc_req_if.sink     req,
   pdc_rsp_if.source   rsp
);

   logic      q_push, q_full, q_pop, q_empty;
   entry_type q_entry, q_head;

   pdc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   pdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (q_head),
      .empty      (q_empty)
   );

   pdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp        (rsp)
   );

endmodule

// ===== rtl/core/pdc_checker.sv =====
// Port-level checks on the result channel of the packet deframer, and the
// bind that attaches them to the top level. Uses pdc_pkg.
module pdc_checker import pdc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_packet_type,
   input logic [31:0] rsp_payload_length,
   input logic        rsp_last
);

   // hold a stalled beat
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a data beat carries no status
   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_DATA |-> rsp_status == ST_OK)
      else $error("data beat with nonzero status");

   // a status beat carries no byte and ends its item
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_STATUS |->
         rsp_payload_byte == 8'd0 && rsp_last)
      else $error("malformed status beat");

   // a beat that does not end its item is followed at once by the status beat
   a_pair_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_result_kind == KIND_STATUS &&
         $stable(rsp_packet_type) && $stable(rsp_payload_length))
      else $error("final payload byte not followed by its status");

endmodule

bind packet_deframer_crc32_check pdc_checker u_pdc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_result_kind    (rsp.result_kind),
   .rsp_payload_byte   (rsp.payload_byte),
   .rsp_status         (rsp.status),
   .rsp_packet_type    (rsp.packet_type),
   .rsp_payload_length (rsp.payload_length),
   .rsp_last           (rsp.last)
);
